FILE: sv/dsfu_pkg.sv
`default_nettype none
package dsfu_pkg;

	localparam int unsigned WORD_W     = 64;
	localparam int unsigned HALF_W     = 32;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CFG_INDEX_W = 8;

	localparam logic [WORD_W-1:0] GOLDEN_GAMMA      = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WORD_W-1:0] MIX_MUL_A         = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_B         = 64'h94D0_49BB_1331_11EB;
	localparam logic [WORD_W-1:0] SEED_FIRST_RESET  = 64'h243F_6A88_85A3_08D3;
	localparam logic [WORD_W-1:0] SEED_SECOND_RESET = 64'h1319_8A2E_0370_7344;

	localparam logic [CFG_INDEX_W-1:0] REG_SEED_FIRST  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEED_SECOND = 8'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL1,
		ST_MUL2,
		ST_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		MS_LL,
		MS_LH,
		MS_HL
	} mul_step_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} mul_req_t;

	function automatic logic [WORD_W-1:0] rotl31(input logic [WORD_W-1:0] v);
		return {v[32:0], v[63:33]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl29(input logic [WORD_W-1:0] v);
		return {v[34:0], v[63:35]};
	endfunction

endpackage
`default_nettype wire

FILE: sv/dsfu_mul64.sv
`default_nettype none
module dsfu_mul64 (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dsfu_pkg::mul_req_t        req,
	output logic                           done,
	output logic [dsfu_pkg::WORD_W-1:0]    p
);

	logic [dsfu_pkg::WORD_W-1:0] a_q;
	logic [dsfu_pkg::WORD_W-1:0] b_q;
	logic [dsfu_pkg::WORD_W-1:0] acc_q;
	dsfu_pkg::mul_step_t         step_q;
	logic                        run_q;
	logic                        done_q;

	logic [dsfu_pkg::HALF_W-1:0] mx;
	logic [dsfu_pkg::HALF_W-1:0] my;
	logic [dsfu_pkg::WORD_W-1:0] prod;

	always_comb begin
		mx = (step_q == dsfu_pkg::MS_HL) ? a_q[63:32] : a_q[31:0];
		my = (step_q == dsfu_pkg::MS_LH) ? b_q[63:32] : b_q[31:0];
		prod = {32'd0, mx} * {32'd0, my};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= dsfu_pkg::MS_LL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= dsfu_pkg::MS_LL;
			end else if (run_q) begin
				case (step_q)
					dsfu_pkg::MS_LL: step_q <= dsfu_pkg::MS_LH;
					dsfu_pkg::MS_LH: step_q <= dsfu_pkg::MS_HL;
					dsfu_pkg::MS_HL: begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
						step_q <= dsfu_pkg::MS_LL;
					end
					default: step_q <= dsfu_pkg::MS_LL;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (run_q) begin
			case (step_q)
				dsfu_pkg::MS_LL: acc_q <= prod;
				dsfu_pkg::MS_LH, dsfu_pkg::MS_HL: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule
`default_nettype wire

FILE: sv/dual_splitmix_fingerprint_unit.sv
// The result for a last item is registered in the emit state, once the output is free.
// The input takes no new item until the current one is fully processed; four 64-bit
// multiplies per item pass through one 32x32 multiplier, three passes each.
// The result register holds while the next record streams in.
// Reset (arst_n low, asynchronous): seeds and chains take their reset values,
// no result is pending and the input side is ready.
`default_nettype none
module dual_splitmix_fingerprint_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [63:0]                      s_axis_tdata,  // value
	input  wire logic                             s_axis_tuser,  // is_byte
	input  wire logic                             s_axis_tlast,  // last
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [191:0]                          m_axis_tdata,  // hash_first, hash_second, table_key
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dsfu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [63:0]                      cfg_data
);

	dsfu_pkg::seq_state_t state_q;
	dsfu_pkg::seq_state_t state_d;

	logic [63:0]  seed_first_q;
	logic [63:0]  seed_second_q;
	logic [63:0]  chain_first_q;
	logic [63:0]  chain_second_q;
	logic [63:0]  value_q;
	logic         is_byte_q;
	logic         last_q;
	logic         sel_q;
	logic         m_valid_q;
	logic [191:0] out_q;

	logic [63:0]  byte_ext;
	logic [63:0]  operand;
	logic [63:0]  chain_cur;
	logic [63:0]  pre_add;
	logic [63:0]  pre_mix;
	logic [63:0]  mid_mix;
	logic [63:0]  fin_mix;
	logic         in_ready;
	logic         chain_wr;
	logic         emit;
	logic         out_free;
	logic         mul_done;
	logic [63:0]  mul_p;

	dsfu_pkg::mul_req_t mul_req;

	dsfu_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_comb begin
		byte_ext = {56'd0, value_q[7:0]};
		if (sel_q) begin
			chain_cur = chain_second_q;
			operand   = is_byte_q ? (byte_ext + dsfu_pkg::GOLDEN_GAMMA)
			                      : dsfu_pkg::rotl31(value_q);
		end else begin
			chain_cur = chain_first_q;
			operand   = is_byte_q ? byte_ext : value_q;
		end
		pre_add = (chain_cur ^ operand) + dsfu_pkg::GOLDEN_GAMMA;
		pre_mix = pre_add ^ (pre_add >> 30);
		mid_mix = mul_p ^ (mul_p >> 27);
		fin_mix = mul_p ^ (mul_p >> 31);
	end

	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		chain_wr      = 1'b0;
		emit          = 1'b0;
		mul_req.start = 1'b0;
		mul_req.a     = pre_mix;
		mul_req.b     = dsfu_pkg::MIX_MUL_A;
		case (state_q)
			dsfu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = dsfu_pkg::ST_PREP;
				end
			end
			dsfu_pkg::ST_PREP: begin
				mul_req.start = 1'b1;
				state_d       = dsfu_pkg::ST_MUL1;
			end
			dsfu_pkg::ST_MUL1: begin
				mul_req.a = mid_mix;
				mul_req.b = dsfu_pkg::MIX_MUL_B;
				if (mul_done) begin
					mul_req.start = 1'b1;
					state_d       = dsfu_pkg::ST_MUL2;
				end
			end
			dsfu_pkg::ST_MUL2: begin
				if (mul_done) begin
					chain_wr = 1'b1;
					if (!sel_q) begin
						state_d = dsfu_pkg::ST_PREP;
					end else if (last_q) begin
						state_d = dsfu_pkg::ST_EMIT;
					end else begin
						state_d = dsfu_pkg::ST_IDLE;
					end
				end
			end
			dsfu_pkg::ST_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = dsfu_pkg::ST_IDLE;
				end
			end
			default: state_d = dsfu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsfu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_first_q   <= dsfu_pkg::SEED_FIRST_RESET;
			seed_second_q  <= dsfu_pkg::SEED_SECOND_RESET;
			chain_first_q  <= dsfu_pkg::SEED_FIRST_RESET;
			chain_second_q <= dsfu_pkg::SEED_SECOND_RESET;
			sel_q          <= 1'b0;
			m_valid_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					dsfu_pkg::REG_SEED_FIRST:  seed_first_q  <= cfg_data;
					dsfu_pkg::REG_SEED_SECOND: seed_second_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_ready && s_axis_tvalid) begin
				sel_q <= 1'b0;
			end
			if (chain_wr) begin
				if (sel_q) begin
					chain_second_q <= fin_mix;
				end else begin
					chain_first_q <= fin_mix;
				end
				sel_q <= !sel_q;
			end
			if (emit) begin
				chain_first_q  <= seed_first_q;
				chain_second_q <= seed_second_q;
				m_valid_q      <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && s_axis_tvalid) begin
			value_q   <= s_axis_tdata;
			is_byte_q <= s_axis_tuser;
			last_q    <= s_axis_tlast;
		end
		if (emit) begin
			out_q <= {chain_first_q ^ dsfu_pkg::rotl29(chain_second_q),
			          chain_second_q, chain_first_q};
		end
	end

	assign s_axis_tready = in_ready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;
	assign cfg_ready     = 1'b1;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted twice in a row");

	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == dsfu_pkg::ST_MUL1 || state_q == dsfu_pkg::ST_MUL2))
		else $error("multiplier finished outside a wait state");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dsfu_pkg::ST_EMIT && m_axis_tvalid && !m_axis_tready
		|=> state_q == dsfu_pkg::ST_EMIT)
		else $error("result emitted over a pending transaction");

	a_key_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[191:128] ==
		(m_axis_tdata[63:0] ^ {m_axis_tdata[98:64], m_axis_tdata[127:99]}))
		else $error("table key does not match hash chains");
`endif

endmodule
`default_nettype wire
